FILE: hdl/adp_pkg.sv
// adp_pkg: shared constants, register codes and the configuration struct
// of the adagrad parameter update block
// depends on nothing
package adp_pkg;

  // default storage sizes
  localparam int unsigned TENSORS_DEF  = 16;
  localparam int unsigned ELEMENTS_DEF = 65536;

  // accumulated square width, unsigned Q32.16
  localparam int unsigned SUM_W = 48;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DECAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_WGT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REG_MODE   = 3'd5;

  // reset values
  localparam logic [31:0] LEARN_RATE_RST = 32'd655;
  localparam logic [15:0] EPSILON_RST    = 16'd1;

  // 1.0 in Q16.16, and the full scale of the sum
  localparam logic [64:0]      ONE_Q16 = 65'h1_0000;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic [31:0] learn_rate;
    logic [31:0] rate_decay;
    logic [31:0] decay_wgt;
    logic [15:0] epsilon;
    logic        maximize;
    logic        l2_mode;
  } cfg_t;

endpackage

FILE: hdl/adp_if.sv
// adp_if: handshake channels of the adagrad parameter update block
// request, response and configuration write; no dependencies
interface adp_req_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  tensor_index;
  logic        [15:0] element_index;
  logic               first_of_tensor;
  logic signed [31:0] param_value;
  logic signed [31:0] grad_value;

  modport source (output valid, tensor_index, element_index, first_of_tensor,
                  param_value, grad_value, input ready);
  modport sink   (input valid, tensor_index, element_index, first_of_tensor,
                  param_value, grad_value, output ready);
endinterface

interface adp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_param_value;
  logic               saturated;

  modport source (output valid, new_param_value, saturated, input ready);
  modport sink   (input valid, new_param_value, saturated, output ready);
endinterface

interface adp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/adp_front.sv
// adp_front: takes request transactions, folds the indices into range
// and hands packed items to the queue; uses adp_pkg and adp_req_if
module adp_front
  import adp_pkg::*;
#(
  parameter int unsigned TENSORS  = TENSORS_DEF,
  parameter int unsigned ELEMENTS = ELEMENTS_DEF,
  localparam int unsigned TW     = (TENSORS > 1) ? $clog2(TENSORS) : 1,
  localparam int unsigned EW     = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1,
  localparam int unsigned ITEM_W = TW + EW + 1 + 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  adp_req_if.sink           req,
  input  logic              clear_busy_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output logic [ITEM_W-1:0] push_data_o
);

  typedef enum logic [1:0] {F_IDLE, F_REDUCE, F_PUSH} f_state_e;

  f_state_e           state_q;
  logic        [3:0]  t_q;
  logic        [15:0] e_q;
  logic               first_q;
  logic signed [31:0] p_q;
  logic signed [31:0] g_q;
  logic        [3:0]  j_q;

  logic [39:0] t_lim;
  logic [47:0] e_lim;
  logic        t_ge;
  logic        e_ge;

  // shifted modulus for this reduction step
  always_comb begin
    t_lim = 40'(TENSORS) << j_q;
    e_lim = 48'(ELEMENTS) << j_q;
    t_ge  = {36'd0, t_q} >= t_lim;
    e_ge  = {32'd0, e_q} >= e_lim;
  end

  assign req.ready    = (state_q == F_IDLE) && !clear_busy_i;
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = {TW'(t_q), EW'(e_q), first_q, p_q, g_q};

  // capture, reduce one shifted modulus a cycle, then push
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      j_q     <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (req.valid && req.ready) begin
            t_q     <= req.tensor_index;
            e_q     <= req.element_index;
            first_q <= req.first_of_tensor;
            p_q     <= req.param_value;
            g_q     <= req.grad_value;
            j_q     <= 4'd15;
            state_q <= F_REDUCE;
          end
        end
        F_REDUCE: begin
          if (t_ge) t_q <= t_q - t_lim[3:0];
          if (e_ge) e_q <= e_q - e_lim[15:0];
          j_q <= j_q - 4'd1;
          if (j_q == 4'd0) state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/adp_fifo.sv
// adp_fifo: two-entry queue between the front and the back
// depends on nothing
module adp_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hdl/adp_div.sv
// adp_div: 64 by 64 bit restoring divider, one quotient bit a cycle
// depends on nothing
module adp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] rem_q;
  logic [63:0] num_q;
  logic [63:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [64:0] rem_sh;
  logic        ge;
  logic [64:0] rem_n;

  // one compare and subtract
  always_comb begin
    rem_sh = {rem_q, num_q[63]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_n  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      rem_q  <= '0;
      num_q  <= num_i;
      den_q  <= den_i;
      cnt_q  <= 6'd63;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= rem_n[63:0];
      num_q <= {num_q[62:0], ge};
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

endmodule

FILE: hdl/adp_sqrt.sv
// adp_sqrt: integer square root of a 64 bit value, one root bit a cycle
// depends on nothing
module adp_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] val_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] rem_n;

  // bring down two bits, try root*4+1
  always_comb begin
    rem_sh = {rem_q, val_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_n  = ge ? (rem_sh - trial) : rem_sh;
  end

  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= 5'd31;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      val_q  <= {val_q[61:0], 2'b00};
      rem_q  <= rem_n[33:0];
      root_q <= {root_q[30:0], ge};
      cnt_q  <= cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

endmodule

FILE: hdl/adp_back.sv
// adp_back: sequencer that carries out one update, owns the step counters
// and the sum store; uses adp_pkg, adp_div, adp_sqrt and adp_rsp_if
module adp_back
  import adp_pkg::*;
#(
  parameter int unsigned TENSORS  = TENSORS_DEF,
  parameter int unsigned ELEMENTS = ELEMENTS_DEF,
  localparam int unsigned TW     = (TENSORS > 1) ? $clog2(TENSORS) : 1,
  localparam int unsigned EW     = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1,
  localparam int unsigned ITEM_W = TW + EW + 1 + 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  logic [ITEM_W-1:0] pop_data_i,
  output logic              clear_busy_o,
  adp_rsp_if.source         rsp
);

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_PREP, B_GADJ, B_SQ, B_SUM,
    B_WAIT1, B_MUL2, B_DIV2, B_WAIT2, B_OUT
  } b_state_e;

  localparam logic signed [49:0] G_MAX = 50'sd2147483647;
  localparam logic signed [49:0] G_MIN = -50'sd2147483648;
  localparam logic signed [35:0] R_MAX = 36'sd2147483647;
  localparam logic signed [35:0] R_MIN = -36'sd2147483648;
  localparam logic [33:0]        Q_CAP = 34'h2_0000_0000;
  localparam logic [EW-1:0]      LAST_ADDR = EW'(ELEMENTS - 1);

  b_state_e           state_q;
  logic [EW-1:0]      clr_addr_q;
  logic [TW-1:0]      t_q;
  logic [EW-1:0]      e_q;
  logic               first_q;
  logic signed [31:0] p_q;
  logic signed [31:0] g_q;
  logic [31:0]        cnt_q [TENSORS];
  logic [SUM_W-1:0]   mem [ELEMENTS];
  logic [SUM_W-1:0]   rdata_q;
  logic signed [32:0] gm_q;
  logic signed [64:0] prod_q;
  logic [31:0]        k_q;
  logic signed [31:0] gc_q;
  logic [31:0]        mag_q;
  logic               sat_q;
  logic [63:0]        kprod_q;
  logic [46:0]        sq_q;
  logic [63:0]        prod2_q;
  logic [32:0]        d_q;
  logic signed [31:0] res_q;

  // item fields at the queue head
  logic [TW-1:0]      head_t;
  logic [EW-1:0]      head_e;
  logic               head_first;
  logic signed [31:0] head_p;
  logic signed [31:0] head_g;
  assign {head_t, head_e, head_first, head_p, head_g} = pop_data_i;

  assign pop_ready_o  = (state_q == B_IDLE);
  assign clear_busy_o = (state_q == B_CLEAR);
  assign rsp.valid           = (state_q == B_OUT);
  assign rsp.new_param_value = res_q;
  assign rsp.saturated       = sat_q;

  // step counter update
  logic [31:0] cnt_cur;
  logic [31:0] cnt_new;
  always_comb begin
    cnt_cur = cnt_q[t_q];
    cnt_new = (first_q && (cnt_cur != 32'hFFFF_FFFF)) ? cnt_cur + 32'd1 : cnt_cur;
  end

  // gradient with weight decay, clamped to 32 bits
  logic signed [49:0] gm_ext;
  logic signed [49:0] adj;
  logic signed [49:0] g2;
  logic signed [31:0] gc;
  logic               g_sat;
  logic [31:0]        mag;
  always_comb begin
    gm_ext = gm_q;
    adj    = '0;
    if (cfg_i.decay_wgt != 32'd0) begin
      if (!cfg_i.l2_mode) begin
        if (p_q > 32'sd0)      adj = $signed({18'd0, cfg_i.decay_wgt});
        else if (p_q < 32'sd0) adj = -$signed({18'd0, cfg_i.decay_wgt});
      end else begin
        adj = 50'(prod_q >>> 16);
      end
    end
    g2    = gm_ext + adj;
    g_sat = 1'b0;
    if (g2 > G_MAX) begin
      gc    = 32'sh7FFF_FFFF;
      g_sat = 1'b1;
    end else if (g2 < G_MIN) begin
      gc    = 32'sh8000_0000;
      g_sat = 1'b1;
    end else begin
      gc = 32'(g2);
    end
    mag = gc[31] ? (~gc + 32'd1) : gc;
  end

  // rate denominator, saturating at full scale
  logic [64:0] den_sum;
  logic [63:0] rate_den;
  logic [63:0] mag_sq;
  always_comb begin
    den_sum  = {1'b0, kprod_q} + ONE_Q16;
    rate_den = den_sum[64] ? '1 : den_sum[63:0];
    mag_sq   = mag_q * mag_q;
  end

  // accumulated sum, saturating
  logic [SUM_W:0]   sum_full;
  logic [SUM_W-1:0] sum_new;
  logic             sum_sat;
  always_comb begin
    sum_full = {1'b0, rdata_q} + (SUM_W + 1)'(sq_q);
    sum_sat  = sum_full[SUM_W];
    sum_new  = sum_sat ? SUM_MAX : sum_full[SUM_W-1:0];
  end

  // shared divider and root unit
  logic        div_start;
  logic [63:0] div_num;
  logic [63:0] div_den;
  logic        div_done;
  logic [63:0] div_quot;
  logic        sqrt_start;
  logic        sqrt_done;
  logic [31:0] sqrt_root;

  always_comb begin
    div_start = 1'b0;
    div_num   = {prod2_q};
    div_den   = 64'(d_q);
    if (state_q == B_SQ) begin
      div_start = 1'b1;
      div_num   = {16'd0, cfg_i.learn_rate, 16'd0};
      div_den   = rate_den;
    end else if ((state_q == B_DIV2) && (d_q != 33'd0)) begin
      div_start = 1'b1;
    end
    sqrt_start = (state_q == B_SUM);
  end

  adp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  adp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   ({sum_new, 16'd0}),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // final quotient cap and result clamp
  logic [33:0]        q_cap;
  logic signed [35:0] res_full;
  always_comb begin
    if ((|div_quot[63:34]) || (div_quot[33] && (|div_quot[32:0]))) q_cap = Q_CAP;
    else q_cap = div_quot[33:0];
    if (gc_q[31]) res_full = 36'(p_q) + $signed({2'b00, q_cap});
    else          res_full = 36'(p_q) - $signed({2'b00, q_cap});
  end

  // sum store: one write port, one registered read port
  logic             mem_we;
  logic [EW-1:0]    mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  always_comb begin
    mem_we    = (state_q == B_CLEAR) || (state_q == B_SUM);
    mem_waddr = (state_q == B_CLEAR) ? clr_addr_q : e_q;
    mem_wdata = (state_q == B_CLEAR) ? '0 : sum_new;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (pop_valid_i && pop_ready_o) rdata_q <= mem[head_e];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_CLEAR;
      clr_addr_q <= '0;
      for (int i = 0; i < TENSORS; i++) cnt_q[i] <= '0;
    end else begin
      case (state_q)
        B_CLEAR: begin
          clr_addr_q <= clr_addr_q + EW'(1);
          if (clr_addr_q == LAST_ADDR) state_q <= B_IDLE;
        end
        B_IDLE: begin
          if (pop_valid_i) begin
            t_q     <= head_t;
            e_q     <= head_e;
            first_q <= head_first;
            p_q     <= head_p;
            g_q     <= head_g;
            state_q <= B_PREP;
          end
        end
        B_PREP: begin
          gm_q       <= cfg_i.maximize ? -33'(g_q) : 33'(g_q);
          prod_q     <= $signed({1'b0, cfg_i.decay_wgt}) * p_q;
          cnt_q[t_q] <= cnt_new;
          k_q        <= (cnt_new == 32'd0) ? 32'd0 : cnt_new - 32'd1;
          state_q    <= B_GADJ;
        end
        B_GADJ: begin
          gc_q    <= gc;
          mag_q   <= mag;
          sat_q   <= g_sat;
          kprod_q <= k_q * cfg_i.rate_decay;
          state_q <= B_SQ;
        end
        B_SQ: begin
          sq_q    <= mag_sq[62:16];
          state_q <= B_SUM;
        end
        B_SUM: begin
          sat_q   <= sat_q | sum_sat;
          state_q <= B_WAIT1;
        end
        B_WAIT1: begin
          if (div_done && sqrt_done) state_q <= B_MUL2;
        end
        B_MUL2: begin
          prod2_q <= div_quot[31:0] * mag_q;
          d_q     <= 33'(sqrt_root) + 33'(cfg_i.epsilon);
          state_q <= B_DIV2;
        end
        B_DIV2: begin
          if (d_q == 33'd0) begin
            res_q   <= p_q;
            state_q <= B_OUT;
          end else begin
            state_q <= B_WAIT2;
          end
        end
        B_WAIT2: begin
          if (div_done) begin
            if (res_full > R_MAX) begin
              res_q <= 32'sh7FFF_FFFF;
              sat_q <= 1'b1;
            end else if (res_full < R_MIN) begin
              res_q <= 32'sh8000_0000;
              sat_q <= 1'b1;
            end else begin
              res_q <= 32'(res_full);
            end
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (rsp.ready) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/adagrad_param_update.sv
// adagrad_param_update: one response per request; the front folds the indices into range
// and the back computes the update with the shared 64-step divider, run up to twice per
// item (rate, then update quotient, skipped when the root plus epsilon is zero)
// the back works on one item at a time; the front and the two-entry queue take further
// requests while the back still works on the previous one
// reset clears the step counters at once, then sweeps every address of the sum store to zero
module adagrad_param_update
  import adp_pkg::*;
#(
  parameter int unsigned TENSORS  = TENSORS_DEF,
  parameter int unsigned ELEMENTS = ELEMENTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  adp_req_if.sink   req_i,
  adp_rsp_if.source rsp_o,
  adp_cfg_if.sink   cfg_i
);

  localparam int unsigned TW     = (TENSORS > 1) ? $clog2(TENSORS) : 1;
  localparam int unsigned EW     = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int unsigned ITEM_W = TW + EW + 1 + 64;

  cfg_t cfg_q;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_rate <= LEARN_RATE_RST;
      cfg_q.rate_decay <= '0;
      cfg_q.decay_wgt  <= '0;
      cfg_q.epsilon    <= EPSILON_RST;
      cfg_q.maximize   <= 1'b0;
      cfg_q.l2_mode    <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_LEARN_RATE: cfg_q.learn_rate <= cfg_i.data;
        REG_RATE_DECAY: cfg_q.rate_decay <= cfg_i.data;
        REG_DECAY_WGT:  cfg_q.decay_wgt  <= cfg_i.data;
        REG_EPSILON:    cfg_q.epsilon    <= cfg_i.data[15:0];
        REG_MAXIMIZE:   cfg_q.maximize   <= cfg_i.data[0];
        REG_REG_MODE:   cfg_q.l2_mode    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  logic              clear_busy;
  logic              push_valid;
  logic              push_ready;
  logic [ITEM_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [ITEM_W-1:0] pop_data;

  adp_front #(.TENSORS(TENSORS), .ELEMENTS(ELEMENTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .clear_busy_i (clear_busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  adp_fifo #(.WIDTH(ITEM_W)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_data_i   (push_data),
    .out_valid_o (pop_valid),
    .out_ready_i (pop_ready),
    .out_data_o  (pop_data)
  );

  adp_back #(.TENSORS(TENSORS), .ELEMENTS(ELEMENTS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .clear_busy_o (clear_busy),
    .rsp          (rsp_o)
  );

  // no request taken while the sum store is being cleared
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !req_i.ready)
    else $error("request accepted during clearing pass");

  // no response can exist before the store is cleared
  a_no_rsp_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !rsp_o.valid)
    else $error("response raised during clearing pass");

  // the back returns to idle after each response transaction
  a_rsp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.ready |=> !rsp_o.valid)
    else $error("response repeated after transaction");

endmodule
